>>> rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // Stream and configuration port widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] HALF_PERIOD_RESET = 16'd2;
  localparam logic [CFG_DATA_W-1:0] ACK_TIMEOUT_RESET = 16'd250;

  // Parameter defaults
  localparam int unsigned TICK_COUNTER_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF       = 2;

  // Bus command codes as they arrive on the request stream
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  typedef enum logic [2:0] {
    KIND_TICK,
    KIND_START,
    KIND_STOP,
    KIND_WRITE,
    KIND_WAIT,
    KIND_READ
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ST_B,
    PH_ST_C,
    PH_SP_B,
    PH_SP_C,
    PH_WR_HIGH,
    PH_WR_LOW,
    PH_WR_END,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_AK_A,
    PH_AK_B,
    PH_AK_C,
    PH_WA_B,
    PH_WA_POLL
  } phase_e;

  // Classified request as it sits in the queue
  typedef struct packed {
    kind_e      kind;
    logic [7:0] write_data;
    logic       send_ack;
    logic       sda_sample;
  } item_t;

  // Result item, scl_level in the lowest bit
  typedef struct packed {
    logic       ack_failed;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive_enable;
    logic       sda_level;
    logic       scl_level;
  } result_t;

endpackage

>>> rtl/i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: start, stop, byte write/read and acknowledge wait.
// ----------------------------------------------------------------------------
// Each request on the input stream is one time unit: while idle it may carry
// a bus command, otherwise it moves the pin sequencer by one tick. Every
// request yields exactly one result with the pin levels after it. The engine
// takes one request per clock while the queue is not full. An accepted
// request enters the intake queue of QUEUE_DEPTH entries, and the sequencer
// then updates state and result register together once the output is free.
// Queue and output register let the input flow on until the queue fills
// while a result waits to be taken. Write configuration only while idle.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core
  import i2cm_pkg::*;
#(
  parameter int unsigned TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [2:0] command, [10:3] write_data, [11] send_ack, [12] sda_sample
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [3] busy_res,
  // [4] done_res, [12:5] read_data, [13] ack_failed
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [CFG_DATA_W-1:0] half_period_q, ack_timeout_q;
  logic                  push, q_full, q_valid, pop;
  item_t                 front_item, queue_item;
  result_t               result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_period_q <= HALF_PERIOD_RESET;
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HALF_PERIOD: half_period_q <= cfg_data_i;
        REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  i2cm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .queue_full_i  (q_full),
    .push_o        (push),
    .item_o        (front_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (queue_item)
  );

  i2cm_back #(
    .TICK_COUNTER_BITS (TICK_COUNTER_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (q_valid),
    .item_i        (queue_item),
    .pop_o         (pop),
    .half_period_i (half_period_q),
    .ack_timeout_i (ack_timeout_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_o      (result)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), result};

`ifndef NO_ASSERTIONS
  // A completing request always leaves the engine idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.done_res |-> !result.busy_res)
    else $error("done reported while still busy");

  // A failed acknowledge is only reported once the stop has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && result.ack_failed |-> !result.busy_res)
    else $error("ack failure flagged during a running command");

  // With the output register empty, a queued request shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("queued request not moved to the output register");
`endif

endmodule

>>> rtl/i2cm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_front
// Request intake: unpacks the input stream and classifies each command.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] command, [10:3] write_data, [11] send_ack, [12] sda_sample
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  queue_full_i,
  output logic                  push_o,
  output item_t                 item_o
);

  logic [2:0] cmd;

  assign cmd           = s_axis_tdata[2:0];
  assign s_axis_tready = !queue_full_i;
  assign push_o        = s_axis_tvalid && !queue_full_i;

  always_comb begin
    item_o.write_data = s_axis_tdata[10:3];
    item_o.send_ack   = s_axis_tdata[11];
    item_o.sda_sample = s_axis_tdata[12];
    case (cmd)
      CMD_START: item_o.kind = KIND_START;
      CMD_STOP:  item_o.kind = KIND_STOP;
      CMD_WRITE: item_o.kind = KIND_WRITE;
      CMD_WAIT:  item_o.kind = KIND_WAIT;
      CMD_READ:  item_o.kind = KIND_READ;
      // tick and unused codes only advance time
      default:   item_o.kind = KIND_TICK;
    endcase
  end

endmodule

>>> rtl/i2cm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_queue
// Short request queue between intake and sequencer.
// ----------------------------------------------------------------------------
module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output item_t item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

>>> rtl/i2cm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_back
// Pin sequencer: runs one time unit per request and registers the result.
// ----------------------------------------------------------------------------
module i2cm_back
  import i2cm_pkg::*;
#(
  parameter int unsigned TICK_COUNTER_BITS = TICK_COUNTER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  input  logic [CFG_DATA_W-1:0] half_period_i,
  input  logic [CFG_DATA_W-1:0] ack_timeout_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               result_o
);

  localparam int unsigned TW = TICK_COUNTER_BITS;

  phase_e        phase_q, phase_d;
  logic [TW-1:0] cnt_q, cnt_d;
  logic [3:0]    bit_q, bit_d, bit_inc;
  logic [7:0]    shift_q, shift_d;
  logic [15:0]   ack_wait_q, ack_wait_d;
  logic          scl_q, scl_d;
  logic          sda_q, sda_d;
  logic          sde_q, sde_d;
  logic          ack_choice_q, ack_choice_d;
  logic [7:0]    held_read_q, held_read_d;
  logic          held_fail_q, held_fail_d;
  logic          fail_pend_q, fail_pend_d;
  logic          out_valid_q;
  result_t       result_q;

  logic          step, accept, adv, cnt_dec, load_dly, go_idle, finish, timed_out;
  logic [32:0]   h_ext, lim;
  logic [TW-1:0] delay;

  // Advance when the output register is free or being drained
  assign step    = item_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o   = step;
  assign bit_inc = bit_q + 4'd1;
  assign adv     = step && (phase_q != PH_IDLE) && (cnt_q <= TW'(1));
  assign timed_out = (ack_wait_q >= ack_timeout_i);

  // Delay reload: zero counts as one, saturate to the counter range
  always_comb begin
    h_ext = (half_period_i == '0) ? 33'd1 : 33'(half_period_i);
    lim   = (33'd1 << TW) - 33'd1;
    delay = (h_ext > lim) ? lim[TW-1:0] : h_ext[TW-1:0];
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    accept   = 1'b0;
    cnt_dec  = 1'b0;
    load_dly = 1'b0;
    go_idle  = 1'b0;
    finish   = 1'b0;
    if (step) begin
      if (phase_q == PH_IDLE) begin
        accept = (item_i.kind != KIND_TICK);
        case (item_i.kind)
          KIND_START: phase_d = PH_ST_B;
          KIND_STOP:  phase_d = PH_SP_B;
          KIND_WRITE: phase_d = PH_WR_HIGH;
          KIND_WAIT:  phase_d = PH_WA_B;
          KIND_READ:  phase_d = PH_RD_HIGH;
          default:    phase_d = PH_IDLE;
        endcase
        load_dly = accept;
      end else if (cnt_q > TW'(1)) begin
        cnt_dec = 1'b1;
      end else begin
        case (phase_q)
          PH_ST_B:    begin phase_d = PH_ST_C; load_dly = 1'b1; end
          PH_ST_C:    finish = 1'b1;
          PH_SP_B:    begin phase_d = PH_SP_C; load_dly = 1'b1; end
          PH_SP_C:    finish = 1'b1;
          PH_WR_HIGH: begin phase_d = PH_WR_LOW; load_dly = 1'b1; end
          PH_WR_LOW: begin
            phase_d  = bit_inc[3] ? PH_WR_END : PH_WR_HIGH;
            load_dly = 1'b1;
          end
          PH_WR_END:  finish = 1'b1;
          PH_RD_HIGH: begin
            phase_d  = bit_inc[3] ? PH_AK_A : PH_RD_LOW;
            load_dly = 1'b1;
          end
          PH_RD_LOW:  begin phase_d = PH_RD_HIGH; load_dly = 1'b1; end
          PH_AK_A:    begin phase_d = PH_AK_B; load_dly = 1'b1; end
          PH_AK_B:    begin phase_d = PH_AK_C; load_dly = 1'b1; end
          PH_AK_C:    finish = 1'b1;
          PH_WA_B:    begin phase_d = PH_WA_POLL; load_dly = 1'b1; end
          PH_WA_POLL: begin
            if (!item_i.sda_sample) begin
              finish = 1'b1;
            end else if (timed_out) begin
              phase_d  = PH_SP_B;
              load_dly = 1'b1;
            end
          end
          default:    go_idle = 1'b1;
        endcase
        if (finish) begin
          go_idle = 1'b1;
        end
        if (go_idle) begin
          phase_d = PH_IDLE;
        end
      end
    end
  end

  // Pins, shift data, counters and held status
  always_comb begin
    cnt_d        = cnt_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    ack_wait_d   = ack_wait_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    sde_d        = sde_q;
    ack_choice_d = ack_choice_q;
    held_read_d  = held_read_q;
    held_fail_d  = held_fail_q;
    fail_pend_d  = fail_pend_q;

    if (load_dly) begin
      cnt_d = delay;
    end else if (go_idle) begin
      cnt_d = '0;
    end else if (cnt_dec) begin
      cnt_d = cnt_q - TW'(1);
    end

    if (accept) begin
      held_fail_d = 1'b0;
      fail_pend_d = 1'b0;
      case (item_i.kind)
        KIND_START: begin sde_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1; end
        KIND_STOP:  begin sde_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0; end
        KIND_WRITE: begin
          shift_d = item_i.write_data;
          bit_d   = '0;
          sde_d   = 1'b1;
          scl_d   = 1'b0;
          sda_d   = item_i.write_data[7];
        end
        KIND_WAIT:  begin sde_d = 1'b0; sda_d = 1'b1; end
        KIND_READ: begin
          ack_choice_d = item_i.send_ack;
          shift_d      = '0;
          bit_d        = '0;
          sde_d        = 1'b0;
          scl_d        = 1'b0;
        end
        default: ;
      endcase
    end else if (adv) begin
      case (phase_q)
        PH_ST_B:    sda_d = 1'b0;
        PH_ST_C:    scl_d = 1'b0;
        PH_SP_B:    begin scl_d = 1'b1; sda_d = 1'b1; end
        PH_SP_C: begin
          if (fail_pend_q) begin
            held_fail_d = 1'b1;
            fail_pend_d = 1'b0;
          end
        end
        PH_WR_HIGH: scl_d = 1'b1;
        PH_WR_LOW: begin
          scl_d   = 1'b0;
          bit_d   = bit_inc;
          shift_d = {shift_q[6:0], 1'b0};
          sda_d   = shift_q[6];
        end
        PH_RD_HIGH: begin
          scl_d   = 1'b1;
          shift_d = {shift_q[6:0], item_i.sda_sample};
          bit_d   = bit_inc;
        end
        PH_RD_LOW:  scl_d = 1'b0;
        PH_AK_A:    begin scl_d = 1'b0; sde_d = 1'b1; sda_d = !ack_choice_q; end
        PH_AK_B:    scl_d = 1'b1;
        PH_AK_C:    begin scl_d = 1'b0; held_read_d = shift_q; end
        PH_WA_B:    begin scl_d = 1'b1; ack_wait_d = '0; end
        PH_WA_POLL: begin
          if (!item_i.sda_sample) begin
            scl_d = 1'b0;
          end else if (timed_out) begin
            sde_d       = 1'b1;
            scl_d       = 1'b0;
            sda_d       = 1'b0;
            fail_pend_d = 1'b1;
          end else begin
            ack_wait_d = ack_wait_q + 16'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cnt_q        <= '0;
      bit_q        <= '0;
      shift_q      <= '0;
      ack_wait_q   <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      sde_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      held_read_q  <= '0;
      held_fail_q  <= 1'b0;
      fail_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      ack_wait_q   <= ack_wait_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      sde_q        <= sde_d;
      ack_choice_q <= ack_choice_d;
      held_read_q  <= held_read_d;
      held_fail_q  <= held_fail_d;
      fail_pend_q  <= fail_pend_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q.scl_level        <= scl_d;
      result_q.sda_level        <= sda_d;
      result_q.sda_drive_enable <= sde_d;
      result_q.busy_res         <= (phase_d != PH_IDLE);
      result_q.done_res         <= finish;
      result_q.read_data        <= held_read_d;
      result_q.ack_failed       <= held_fail_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule
